@@ hdl/assert_macros.svh @@
// Shared assertion shorthands, clocked on clk with rst_n as the reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mscd_pkg.sv @@
package mscd_pkg;

    // Event kinds on the request channel
    localparam logic [1:0] ACT_BUTTON = 2'd0;
    localparam logic [1:0] ACT_SECOND = 2'd1;
    localparam logic [1:0] ACT_REPEAT = 2'd2;

    // Configuration register indexes
    localparam logic REG_HOLD_REPEATS     = 1'b0;
    localparam logic REG_FAST_SECOND_STEP = 1'b1;

    localparam logic [3:0] HOLD_REPEATS_RESET     = 4'd10;
    localparam logic [2:0] FAST_SECOND_STEP_RESET = 3'd5;

    localparam logic [7:0] SEC_PER_MIN = 8'd60;
    localparam logic [7:0] MIN_PER_HOUR = 8'd60;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SET,
        MODE_RUN,
        MODE_PAUSE,
        MODE_DONE
    } mode_t;

    typedef enum logic [2:0] {
        MSG_NONE,
        MSG_COUNTING,
        MSG_SET,
        MSG_CLEARED,
        MSG_ALARM
    } msg_t;

    typedef struct packed {
        logic [3:0] hold_repeats;
        logic [2:0] fast_second_step;
    } cfg_t;

    typedef struct packed {
        logic [1:0] action;
        logic       minute_button;
        logic       second_button;
        logic       start_button;
        logic       start_held_long;
    } item_t;

    typedef struct packed {
        mode_t      mode;
        logic [5:0] minute_count;
        logic [5:0] second_count;
        logic [2:0] second_step;
        logic       minute_step;
        logic [3:0] repeat_count;
        logic       started;
        logic       halted;
        logic       lamp_level;
    } state_t;

    localparam state_t STATE_RESET = '{
        mode:         MODE_IDLE,
        minute_count: 6'd0,
        second_count: 6'd0,
        second_step:  3'd0,
        minute_step:  1'b0,
        repeat_count: 4'd0,
        started:      1'b0,
        halted:       1'b0,
        lamp_level:   1'b0
    };

endpackage

@@ hdl/minute_second_countdown_timer.sv @@
// Channel   | Handshake                        | Payload
// ----------+----------------------------------+------------------------------------------
// item      | item_valid / item_ready          | action, minute/second/start_button, held
// result    | result_valid / result_ready      | minutes_now, seconds_now, lamp, msg, flags
// config    | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// One request per cycle sustained while result_ready keeps the result register drained.
// The request register feeds one pass of step logic into the state and result registers.
// A full result register that is not taken stalls the step stage; the request register
// then holds one more request before item_ready drops.
// rst_n clears the timer state and the valid flags and sets the configuration registers to their defaults.
`include "assert_macros.svh"

module minute_second_countdown_timer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  action,
    input  logic        minute_button,
    input  logic        second_button,
    input  logic        start_button,
    input  logic        start_held_long,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [5:0]  minutes_now,
    output logic [5:0]  seconds_now,
    output logic        lamp,
    output logic [2:0]  message_code,
    output logic        counting,
    output logic        on_hold,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mscd_pkg::cfg_t   cfg;
    mscd_pkg::item_t  item_reg;
    logic             item_vld_reg;
    logic             item_vld_next;
    mscd_pkg::state_t state_reg;
    mscd_pkg::state_t state_next;
    mscd_pkg::msg_t   msg_next;
    logic             res_vld_reg;
    logic             res_vld_next;
    logic [5:0]       res_min_reg;
    logic [5:0]       res_sec_reg;
    logic             res_lamp_reg;
    mscd_pkg::msg_t   res_msg_reg;
    logic             res_cnt_reg;
    logic             res_hold_reg;
    logic             take;
    logic             advance;
    logic             fire;

    mscd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: step when the result register is free or being drained
    assign advance       = ~res_vld_reg | result_ready;
    assign fire          = item_vld_reg & advance;
    assign item_ready    = ~item_vld_reg | advance;
    assign take          = item_valid & item_ready;
    assign item_vld_next = take | (item_vld_reg & ~advance);
    assign res_vld_next  = fire | (res_vld_reg & ~result_ready);

    // Capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_vld_reg <= 1'b0;
        else
            item_vld_reg <= item_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.action          <= action;
            item_reg.minute_button   <= minute_button;
            item_reg.second_button   <= second_button;
            item_reg.start_button    <= start_button;
            item_reg.start_held_long <= start_held_long;
        end
    end

    mscd_step u_step
    (
        .cur  (state_reg),
        .cfg  (cfg),
        .item (item_reg),
        .nxt  (state_next),
        .msg  (msg_next)
    );

    // Advance the timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mscd_pkg::STATE_RESET;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            res_vld_reg <= res_vld_next;
            if (fire)
                state_reg <= state_next;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_min_reg  <= state_next.minute_count;
            res_sec_reg  <= state_next.second_count;
            res_lamp_reg <= state_next.lamp_level;
            res_msg_reg  <= msg_next;
            res_cnt_reg  <= state_next.started;
            res_hold_reg <= state_next.halted;
        end
    end

    assign result_valid = res_vld_reg;
    assign minutes_now  = res_min_reg;
    assign seconds_now  = res_sec_reg;
    assign lamp         = res_lamp_reg;
    assign message_code = res_msg_reg;
    assign counting     = res_cnt_reg;
    assign on_hold      = res_hold_reg;

    `ASSERT_SAME(a_halt_needs_start, state_reg.halted, state_reg.started,
        "paused flag set while timer not started")
    `ASSERT_SAME(a_run_flags, state_reg.mode == mscd_pkg::MODE_RUN,
        state_reg.started && !state_reg.halted, "run mode with inconsistent flags")
    `ASSERT_SAME(a_pause_flags, state_reg.mode == mscd_pkg::MODE_PAUSE,
        state_reg.started && state_reg.halted, "pause mode with inconsistent flags")
    `ASSERT_ALWAYS(a_time_range,
        (state_reg.second_count < 6'd60) && (state_reg.minute_count < 6'd60),
        "time value out of range")
    `ASSERT_NEXT(a_step_gives_result, fire, res_vld_reg,
        "stepped request produced no result")

endmodule

@@ hdl/mscd_cfg.sv @@
module mscd_cfg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output mscd_pkg::cfg_t    cfg
);

    mscd_pkg::cfg_t cfg_reg;
    mscd_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Decode the register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                mscd_pkg::REG_HOLD_REPEATS:     cfg_next.hold_repeats     = pwdata[3:0];
                mscd_pkg::REG_FAST_SECOND_STEP: cfg_next.fast_second_step = pwdata[2:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_repeats     <= mscd_pkg::HOLD_REPEATS_RESET;
            cfg_reg.fast_second_step <= mscd_pkg::FAST_SECOND_STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[2])
            mscd_pkg::REG_HOLD_REPEATS:     prdata = {28'd0, cfg_reg.hold_repeats};
            mscd_pkg::REG_FAST_SECOND_STEP: prdata = {29'd0, cfg_reg.fast_second_step};
            default:                        prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/mscd_adjust.sv @@
module mscd_adjust
(
    input  logic [5:0] sec_in,
    input  logic [5:0] min_in,
    input  logic [2:0] dsec,
    input  logic       down,
    input  logic       dmin,
    output logic [5:0] sec_out,
    output logic [5:0] min_out
);

    logic [7:0] s_raw;
    logic [7:0] s_fix;
    logic [7:0] s_wrap;
    logic [7:0] m_raw;
    logic [7:0] m_carry;
    logic       sec_change;
    logic       borrow;
    logic       carry;

    // Step the seconds, borrowing a minute on underflow
    always_comb
    begin
        if (down)
            s_raw = {2'd0, sec_in} - 8'd1;
        else
            s_raw = {2'd0, sec_in} + {5'd0, dsec};
        sec_change = down | (dsec != 3'd0);
        borrow     = (s_raw == 8'd255) && (min_in != 6'd0) && sec_change;
        s_fix      = borrow ? 8'd59 : s_raw;
        if (borrow)
            m_raw = {2'd0, min_in} - 8'd1;
        else
            m_raw = {2'd0, min_in} + {7'd0, dmin};
    end

    // Wrap seconds past a minute and carry; minutes past an hour wrap to zero
    always_comb
    begin
        carry = (s_fix >= mscd_pkg::SEC_PER_MIN);
        if (s_fix >= 8'd240)
            s_wrap = s_fix - 8'd240;
        else if (s_fix >= 8'd180)
            s_wrap = s_fix - 8'd180;
        else if (s_fix >= 8'd120)
            s_wrap = s_fix - 8'd120;
        else if (carry)
            s_wrap = s_fix - mscd_pkg::SEC_PER_MIN;
        else
            s_wrap = s_fix;
        m_carry = m_raw + {7'd0, carry};
        sec_out = s_wrap[5:0];
        min_out = (m_carry >= mscd_pkg::MIN_PER_HOUR) ? 6'd0 : m_carry[5:0];
    end

endmodule

@@ hdl/mscd_step.sv @@
module mscd_step
(
    input  mscd_pkg::state_t cur,
    input  mscd_pkg::cfg_t   cfg,
    input  mscd_pkg::item_t  item,
    output mscd_pkg::state_t nxt,
    output mscd_pkg::msg_t   msg
);

    logic       is_button;
    logic       is_tick;
    logic       start_only;
    logic       time_nonzero;
    logic [2:0] sstep_sel;
    logic       mstep_sel;
    logic [3:0] rep_sel;
    logic       accel;
    logic [2:0] adj_dsec;
    logic       adj_dmin;
    logic [5:0] adj_sec;
    logic [5:0] adj_min;

    assign is_button    = (item.action == mscd_pkg::ACT_BUTTON);
    assign is_tick      = (item.action == mscd_pkg::ACT_SECOND);
    assign start_only   = item.start_button & ~item.minute_button & ~item.second_button;
    assign time_nonzero = (cur.minute_count != 6'd0) || (cur.second_count != 6'd0);

    // Pick the step sizes: a button change loads them, a repeat keeps them
    always_comb
    begin
        if (is_button)
        begin
            sstep_sel = {2'd0, item.second_button};
            mstep_sel = item.minute_button;
            rep_sel   = (item.minute_button & ~item.second_button) ? 4'd0 : cur.repeat_count;
        end
        else
        begin
            sstep_sel = cur.second_step;
            mstep_sel = cur.minute_step;
            rep_sel   = cur.repeat_count;
        end
        accel    = (rep_sel >= cfg.hold_repeats);
        adj_dsec = is_tick ? 3'd0 : sstep_sel;
        adj_dmin = is_tick ? 1'b0 : mstep_sel;
    end

    mscd_adjust u_adjust
    (
        .sec_in  (cur.second_count),
        .min_in  (cur.minute_count),
        .dsec    (adj_dsec),
        .down    (is_tick),
        .dmin    (adj_dmin),
        .sec_out (adj_sec),
        .min_out (adj_min)
    );

    // Next state and message for one event
    always_comb
    begin
        nxt = cur;
        msg = mscd_pkg::MSG_NONE;
        unique case (item.action)
            mscd_pkg::ACT_BUTTON:
            begin
                if (start_only)
                begin
                    if (item.start_held_long)
                    begin
                        nxt.minute_count = 6'd0;
                        nxt.second_count = 6'd0;
                        nxt.halted       = 1'b0;
                        nxt.started      = 1'b0;
                        nxt.mode         = mscd_pkg::MODE_IDLE;
                        nxt.lamp_level   = 1'b0;
                        msg              = mscd_pkg::MSG_CLEARED;
                    end
                    else if (time_nonzero)
                    begin
                        if (!cur.started)
                        begin
                            nxt.started = 1'b1;
                            nxt.mode    = mscd_pkg::MODE_RUN;
                            msg         = mscd_pkg::MSG_COUNTING;
                        end
                        else if (cur.halted)
                        begin
                            nxt.halted = 1'b0;
                            nxt.mode   = mscd_pkg::MODE_RUN;
                        end
                        else
                        begin
                            nxt.halted = 1'b1;
                            nxt.mode   = mscd_pkg::MODE_PAUSE;
                        end
                    end
                    else
                    begin
                        nxt.mode       = mscd_pkg::MODE_IDLE;
                        nxt.lamp_level = 1'b0;
                    end
                end
                else if (!cur.started)
                begin
                    if (item.minute_button | item.second_button)
                    begin
                        // Enter set mode and take one step at once
                        nxt.mode         = mscd_pkg::MODE_SET;
                        nxt.minute_step  = mstep_sel;
                        nxt.second_count = adj_sec;
                        nxt.minute_count = adj_min;
                        nxt.second_step  = accel ? cfg.fast_second_step : sstep_sel;
                        nxt.repeat_count = accel ? rep_sel : rep_sel + 4'd1;
                        msg              = mscd_pkg::MSG_SET;
                    end
                    else
                    begin
                        nxt.repeat_count = 4'd0;
                        nxt.mode         = mscd_pkg::MODE_IDLE;
                        nxt.lamp_level   = 1'b0;
                    end
                end
            end
            mscd_pkg::ACT_SECOND:
            begin
                if (cur.mode == mscd_pkg::MODE_RUN)
                begin
                    nxt.second_count = adj_sec;
                    nxt.minute_count = adj_min;
                    if ((adj_sec == 6'd0) && (adj_min == 6'd0))
                    begin
                        nxt.mode       = mscd_pkg::MODE_DONE;
                        nxt.started    = 1'b0;
                        nxt.halted     = 1'b0;
                        nxt.lamp_level = 1'b1;
                        msg            = mscd_pkg::MSG_ALARM;
                    end
                    else
                    begin
                        nxt.lamp_level = ~cur.lamp_level;
                        msg            = mscd_pkg::MSG_COUNTING;
                    end
                end
            end
            mscd_pkg::ACT_REPEAT:
            begin
                if (cur.mode == mscd_pkg::MODE_SET)
                begin
                    nxt.second_count = adj_sec;
                    nxt.minute_count = adj_min;
                    nxt.second_step  = accel ? cfg.fast_second_step : sstep_sel;
                    nxt.repeat_count = accel ? rep_sel : rep_sel + 4'd1;
                    msg              = mscd_pkg::MSG_SET;
                end
            end
            default:
            begin
                nxt = cur;
                msg = mscd_pkg::MSG_NONE;
            end
        endcase
    end

endmodule

@@ sim/minute_second_countdown_timer_tb.sv @@
module minute_second_countdown_timer_tb;
    import mscd_pkg::*;

    // Action code with no meaning to the timer; it must leave the state alone
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int STALL_LIMIT  = 3000;
    localparam int PHASE_EVENTS = 180;

    typedef struct {
        item_t press;
        bit    drain;
    } queued_event_t;

    typedef struct packed {
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       lamp;
        msg_t       msg;
        logic       counting;
        logic       on_hold;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [1:0]  action = 2'd0;
    logic        minute_button = 1'b0;
    logic        second_button = 1'b0;
    logic        start_button = 1'b0;
    logic        start_held_long = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [5:0]  minutes_now;
    logic [5:0]  seconds_now;
    logic        lamp;
    logic [2:0]  message_code;
    logic        counting;
    logic        on_hold;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Timer model state and its settings
    state_t tmr = STATE_RESET;
    cfg_t   cfg = '{hold_repeats: HOLD_REPEATS_RESET, fast_second_step: FAST_SECOND_STEP_RESET};

    queued_event_t event_q[$];
    reading_t      expected_readings[$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  pushed = 0;
    bit  drain_next = 1'b0;
    int  send_gap = 0;
    int  send_burst = 0;
    int  hold_left = 0;
    int  take_burst = 0;
    int  idle_cycles = 0;
    int  roll;
    bit  item_fire;
    item_t         sent_press;
    queued_event_t next_event;
    reading_t      want;

    minute_second_countdown_timer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .action          (action),
        .minute_button   (minute_button),
        .second_button   (second_button),
        .start_button    (start_button),
        .start_held_long (start_held_long),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .minutes_now     (minutes_now),
        .seconds_now     (seconds_now),
        .lamp            (lamp),
        .message_code    (message_code),
        .counting        (counting),
        .on_hold         (on_hold),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Step the time by seconds and minutes, or count one second down
    function automatic void shift_time(logic [7:0] dsec, bit down, logic [7:0] dmin);
        logic [7:0] s;
        logic [7:0] m;
        bit         sec_change;
        s = {2'b00, tmr.second_count};
        m = {2'b00, tmr.minute_count};
        sec_change = down || dsec != 8'd0;
        if (down)
            s = s - 8'd1;
        else
            s = s + dsec;
        // Borrow a minute when the seconds underflow
        if (s == 8'd255 && m != 8'd0 && sec_change)
        begin
            s = SEC_PER_MIN - 8'd1;
            m = m - 8'd1;
        end
        else
        begin
            m = m + dmin;
        end
        if (s >= SEC_PER_MIN)
        begin
            s = s % SEC_PER_MIN;
            m = m + 8'd1;
        end
        if (m >= MIN_PER_HOUR)
            m = 8'd0;
        tmr.second_count = s[5:0];
        tmr.minute_count = m[5:0];
    endfunction

    // One set step; count repeats until the seconds step speeds up
    function automatic void set_step();
        shift_time({5'b00000, tmr.second_step}, 1'b0, {7'b0000000, tmr.minute_step});
        if (tmr.repeat_count >= cfg.hold_repeats)
            tmr.second_step = cfg.fast_second_step;
        else
            tmr.repeat_count = tmr.repeat_count + 4'd1;
    endfunction

    function automatic reading_t advance_timer(item_t ev);
        msg_t     msg;
        reading_t r;
        msg = MSG_NONE;
        case (ev.action)
            ACT_BUTTON:
            begin
                if (ev.start_button && !ev.minute_button && !ev.second_button)
                begin
                    if (ev.start_held_long)
                    begin
                        // long hold clears everything
                        tmr.minute_count = 6'd0;
                        tmr.second_count = 6'd0;
                        tmr.halted = 1'b0;
                        tmr.started = 1'b0;
                        tmr.mode = MODE_IDLE;
                        tmr.lamp_level = 1'b0;
                        msg = MSG_CLEARED;
                    end
                    else if (tmr.minute_count != 6'd0 || tmr.second_count != 6'd0)
                    begin
                        if (!tmr.started)
                        begin
                            tmr.started = 1'b1;
                            tmr.mode = MODE_RUN;
                            msg = MSG_COUNTING;
                        end
                        else if (tmr.halted)
                        begin
                            tmr.halted = 1'b0;
                            tmr.mode = MODE_RUN;
                        end
                        else
                        begin
                            tmr.halted = 1'b1;
                            tmr.mode = MODE_PAUSE;
                        end
                    end
                    else
                    begin
                        tmr.mode = MODE_IDLE;
                        tmr.lamp_level = 1'b0;
                    end
                end
                else if (!tmr.started)
                begin
                    if (ev.minute_button && ev.second_button)
                    begin
                        tmr.minute_step = 1'b1;
                        tmr.second_step = 3'd1;
                        tmr.mode = MODE_SET;
                    end
                    else if (ev.minute_button)
                    begin
                        tmr.second_step = 3'd0;
                        tmr.minute_step = 1'b1;
                        tmr.repeat_count = 4'd0;
                        tmr.mode = MODE_SET;
                    end
                    else if (ev.second_button)
                    begin
                        tmr.second_step = 3'd1;
                        tmr.minute_step = 1'b0;
                        tmr.mode = MODE_SET;
                    end
                    else
                    begin
                        tmr.repeat_count = 4'd0;
                        tmr.mode = MODE_IDLE;
                        tmr.lamp_level = 1'b0;
                    end
                    if (tmr.mode == MODE_SET)
                    begin
                        set_step();
                        msg = MSG_SET;
                    end
                end
            end
            ACT_SECOND:
            begin
                if (tmr.mode == MODE_RUN)
                begin
                    tmr.lamp_level = ~tmr.lamp_level;
                    shift_time(8'd0, 1'b1, 8'd0);
                    if (tmr.minute_count == 6'd0 && tmr.second_count == 6'd0)
                    begin
                        tmr.mode = MODE_DONE;
                        tmr.started = 1'b0;
                        tmr.halted = 1'b0;
                        tmr.lamp_level = 1'b1;
                        msg = MSG_ALARM;
                    end
                    else
                    begin
                        msg = MSG_COUNTING;
                    end
                end
            end
            ACT_REPEAT:
            begin
                if (tmr.mode == MODE_SET)
                begin
                    set_step();
                    msg = MSG_SET;
                end
            end
            default: ;
        endcase
        r.minutes = tmr.minute_count;
        r.seconds = tmr.second_count;
        r.lamp = tmr.lamp_level;
        r.msg = msg;
        r.counting = tmr.started;
        r.on_hold = tmr.halted;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int expected_val);
        $display("result %0d: %s got %0d, expected %0d", results_seen, what, got,
                 expected_val);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    // Request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            item_fire = item_valid && item_ready;
            if (item_fire)
            begin
                sent_press = '{action, minute_button, second_button, start_button,
                               start_held_long};
                expected_readings.push_back(advance_timer(sent_press));
                if (send_burst != 0)
                begin
                    send_burst--;
                    send_gap = 0;
                end
                else if ($urandom_range(0, 99) == 0)
                begin
                    send_burst = $urandom_range(20, 60);
                    send_gap = 0;
                end
                else
                begin
                    send_gap = pick_gap();
                end
            end
            if (!item_valid || item_fire)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (event_q.size() != 0 &&
                         !(event_q[0].drain && expected_readings.size() != 0))
                begin
                    next_event = event_q.pop_front();
                    item_valid <= 1'b1;
                    action <= next_event.press.action;
                    minute_button <= next_event.press.minute_button;
                    second_button <= next_event.press.second_button;
                    start_button <= next_event.press.start_button;
                    start_held_long <= next_event.press.start_held_long;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and ready pattern
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_readings.size() == 0)
                begin
                    report_mismatch("result with no request, minutes", minutes_now, -1);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (minutes_now !== want.minutes)
                        report_mismatch("minutes_now", minutes_now, want.minutes);
                    if (seconds_now !== want.seconds)
                        report_mismatch("seconds_now", seconds_now, want.seconds);
                    if (lamp !== want.lamp)
                        report_mismatch("lamp", lamp, want.lamp);
                    if (message_code !== want.msg)
                        report_mismatch("message_code", message_code, want.msg);
                    if (counting !== want.counting)
                        report_mismatch("counting", counting, want.counting);
                    if (on_hold !== want.on_hold)
                        report_mismatch("on_hold", on_hold, want.on_hold);
                end
                // hold off long enough for the block to back up into the sender
                if (results_seen % 300 == 100)
                    hold_left = 150;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (take_burst != 0)
            begin
                take_burst--;
                result_ready <= 1'b1;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                begin
                    hold_left = $urandom_range(8, 30);
                    result_ready <= 1'b0;
                end
                else if (roll < 4)
                begin
                    take_burst = $urandom_range(20, 60);
                    result_ready <= 1'b1;
                end
                else
                begin
                    result_ready <= (roll < 75);
                end
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_event(logic [1:0] act, bit mb, bit sb, bit stb, bit held);
        queued_event_t e;
        e.press = '{act, mb, sb, stb, held};
        e.drain = drain_next;
        drain_next = 1'b0;
        event_q.push_back(e);
        pushed++;
    endtask

    task automatic push_tick(logic [1:0] act);
        push_event(act, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Wait until every request has gone through and every result is back
    task automatic wait_quiet();
        while (event_q.size() != 0 || item_valid || expected_readings.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic queue_directed();
        push_event(ACT_SECOND, 0, 0, 0, 0);
        push_event(ACT_REPEAT, 1, 1, 1, 1);
        push_event(ACT_UNUSED, 1, 0, 1, 0);
        // start at zero time does nothing
        push_event(ACT_BUTTON, 0, 0, 1, 0);
        push_event(ACT_BUTTON, 0, 0, 0, 0);
        push_event(ACT_BUTTON, 0, 1, 0, 0);
        push_event(ACT_REPEAT, 0, 1, 0, 0);
        push_event(ACT_REPEAT, 0, 0, 0, 0);
        push_event(ACT_REPEAT, 0, 1, 0, 0);
        push_event(ACT_BUTTON, 1, 0, 0, 0);
        push_event(ACT_BUTTON, 1, 1, 0, 0);
        push_event(ACT_BUTTON, 0, 0, 0, 0);
        // run, pause, ignored events, resume
        push_event(ACT_BUTTON, 0, 0, 1, 0);
        push_event(ACT_SECOND, 0, 0, 0, 0);
        push_event(ACT_BUTTON, 0, 0, 1, 0);
        push_event(ACT_SECOND, 0, 0, 0, 0);
        push_event(ACT_BUTTON, 1, 0, 0, 0);
        push_event(ACT_BUTTON, 0, 0, 1, 0);
        push_event(ACT_BUTTON, 0, 1, 1, 1);
        // long hold clears, then count one second down to the alarm
        push_event(ACT_BUTTON, 0, 0, 1, 1);
        push_event(ACT_BUTTON, 0, 1, 0, 0);
        push_event(ACT_BUTTON, 0, 0, 0, 1);
        push_event(ACT_BUTTON, 0, 0, 1, 0);
        push_event(ACT_SECOND, 1, 1, 1, 1);
        push_event(ACT_BUTTON, 1, 0, 1, 1);
    endtask

    task automatic queue_random_sequence();
        int kind;
        int n;
        int combo;
        bit mb;
        bit sb;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 29) == 0)
            drain_next = 1'b1;
        if (kind < 30)
        begin
            // hold set buttons through a run of repeat ticks, then release
            combo = $urandom_range(0, 2);
            mb = (combo != 1);
            sb = (combo != 0);
            push_event(ACT_BUTTON, mb, sb, ($urandom_range(0, 4) == 0),
                       1'($urandom_range(0, 1)));
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 8);
            repeat (n)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_tick(ACT_SECOND);
                else if ($urandom_range(0, 14) == 0)
                    push_event(ACT_BUTTON, 1'($urandom_range(0, 1)), 1, 0, 0);
                else
                    push_tick(ACT_REPEAT);
            end
            push_event(ACT_BUTTON, 0, 0, 0, 1'($urandom_range(0, 1)));
        end
        else if (kind < 55)
        begin
            // start, count, maybe pause and resume
            push_event(ACT_BUTTON, 0, 0, 1, 0);
            repeat ($urandom_range(1, 20)) push_tick(ACT_SECOND);
            if ($urandom_range(0, 1) == 1)
            begin
                push_event(ACT_BUTTON, 0, 0, 1, 0);
                repeat ($urandom_range(0, 3)) push_tick(ACT_SECOND);
                if ($urandom_range(0, 3) == 0)
                    push_event(ACT_BUTTON, 1'($urandom_range(0, 1)), 1,
                               1'($urandom_range(0, 1)), 0);
                push_event(ACT_BUTTON, 0, 0, 1, 0);
                repeat ($urandom_range(1, 10)) push_tick(ACT_SECOND);
            end
        end
        else if (kind < 65)
        begin
            // clear, set a few seconds, count down to the alarm
            push_event(ACT_BUTTON, 0, 0, 1, 1);
            push_event(ACT_BUTTON, 0, 1, 0, 0);
            repeat ($urandom_range(0, 3)) push_event(ACT_REPEAT, 0, 1, 0, 0);
            push_event(ACT_BUTTON, 0, 0, 0, 0);
            push_event(ACT_BUTTON, 0, 0, 1, 0);
            repeat ($urandom_range(2, 24)) push_tick(ACT_SECOND);
        end
        else if (kind < 72)
        begin
            push_event(ACT_BUTTON, 0, 0, 1, 1);
        end
        else
        begin
            // noise
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 19) == 0)
                    push_tick(ACT_UNUSED);
                else
                    push_tick(2'($urandom_range(0, 2)));
            end
        end
    endtask

    initial
    begin
        logic [3:0] hr;
        logic [2:0] fs;
        bit         mid_drain;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_quiet();
            case (phase)
                0:
                begin
                    hr = HOLD_REPEATS_RESET;
                    fs = FAST_SECOND_STEP_RESET;
                end
                1:
                begin
                    hr = 4'd0;
                    fs = 3'd1;
                end
                2:
                begin
                    hr = 4'd15;
                    fs = 3'd7;
                end
                default:
                begin
                    hr = 4'($urandom_range(1, 14));
                    fs = 3'($urandom_range(2, 6));
                end
            endcase
            write_reg({REG_HOLD_REPEATS, 2'b00}, {28'd0, hr});
            write_reg({REG_FAST_SECOND_STEP, 2'b00}, {29'd0, fs});
            cfg.hold_repeats = hr;
            cfg.fast_second_step = fs;
            if (phase == 0)
                queue_directed();
            pushed = 0;
            mid_drain = 1'b0;
            while (pushed < PHASE_EVENTS)
            begin
                // halfway through, let the sender wait for every result
                if (!mid_drain && pushed >= PHASE_EVENTS / 2)
                begin
                    drain_next = 1'b1;
                    mid_drain = 1'b1;
                end
                queue_random_sequence();
            end
        end
        wait_quiet();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/mscd_pkg.sv
hdl/mscd_cfg.sv
hdl/mscd_adjust.sv
hdl/mscd_step.sv
hdl/minute_second_countdown_timer.sv
sim/minute_second_countdown_timer_tb.sv
